### rtl/core/indexed_insert_delete_array_assert.svh
// Assertion macros shared by the indexed insert/delete array RTL.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef INDEXED_INSERT_DELETE_ARRAY_ASSERT_SVH
`define INDEXED_INSERT_DELETE_ARRAY_ASSERT_SVH

// Antecedent in a cycle implies consequent in the same cycle
`define IIDA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in a cycle implies consequent in the next cycle
`define IIDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/iida_pkg.sv
// Package for the indexed insert/delete array: sizes, command and status codes,
// and the control struct broadcast along the cell chain. No dependencies.
package iida_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = 7;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int WORD_W   = 64;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4,
    CMD_RESIZE = 3'd5
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e_t;

  localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

  // Per-cycle update broadcast to every cell; at most one enable is set
  typedef struct packed {
    logic              wr;
    logic              app;
    logic              ins;
    logic              del;
    logic              rsz;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  cnt;
    logic [WORD_W-1:0] val;
  } cell_ctl_t;

endpackage

### rtl/core/iida_cell.sv
// One storage cell of the array chain: holds one word and takes its next value
// from the request, its left neighbor, its right neighbor or zero. Uses iida_pkg.
module iida_cell (
  input  logic                        clk,
  input  logic [iida_pkg::POS_W-1:0]  pos,
  input  iida_pkg::cell_ctl_t         ctl,
  input  logic [iida_pkg::WORD_W-1:0] left_word,
  input  logic [iida_pkg::WORD_W-1:0] right_word,
  output logic [iida_pkg::WORD_W-1:0] word,
  output logic [iida_pkg::WORD_W-1:0] sel_word
);
  import iida_pkg::*;

  logic [IDX_W-1:0]  p;
  logic [IDX_W-1:0]  p1;
  logic [WORD_W-1:0] word_next;

  assign p  = IDX_W'(pos);
  assign p1 = p + IDX_W'(1);

  // Pick the next word for this slot
  always_comb begin
    word_next = word;
    priority if (ctl.wr && p == ctl.idx) begin
      word_next = ctl.val;
    end else if (ctl.app && p == ctl.cnt) begin
      word_next = ctl.val;
    end else if (ctl.ins && p == ctl.idx) begin
      word_next = ctl.val;
    end else if (ctl.ins && p > ctl.idx && p <= ctl.cnt) begin
      word_next = left_word;
    end else if (ctl.del && p >= ctl.idx && p1 < ctl.cnt) begin
      word_next = right_word;
    end else if (ctl.rsz && p >= ctl.cnt && p < ctl.idx) begin
      word_next = '0;
    end else begin
      word_next = word;
    end
  end

  // Hold the word
  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // Drive the word onto the read bus when this slot is addressed
  assign sel_word = (p == ctl.idx) ? word : '0;

endmodule

### rtl/core/iida_ctrl.sv
// Command decode and live count for the indexed insert/delete array.
// Uses iida_pkg and the assertion macros header.
`include "indexed_insert_delete_array_assert.svh"
module iida_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [2:0]                  command,
  input  logic [iida_pkg::IDX_W-1:0]  index,
  input  logic [iida_pkg::WORD_W-1:0] write_value,
  output iida_pkg::cell_ctl_t         ctl,
  output logic                        rd_ok,
  output logic [1:0]                  status_next,
  output logic [iida_pkg::IDX_W-1:0]  cnt_next
);
  import iida_pkg::*;

  logic [IDX_W-1:0] live_cnt;
  status_e_t        st;
  logic             wr_ok;
  logic             app_ok;
  logic             ins_ok;
  logic             del_ok;
  logic             rsz_ok;
  logic             in_range;
  logic             full;

  assign in_range = index < live_cnt;
  assign full     = live_cnt >= CAP_IDX;

  // Decode the request and check range and capacity
  always_comb begin
    st     = ST_OK;
    rd_ok  = 1'b0;
    wr_ok  = 1'b0;
    app_ok = 1'b0;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    rsz_ok = 1'b0;
    unique case (cmd_e_t'(command))
      CMD_READ: begin
        if (in_range) rd_ok = 1'b1;
        else          st    = ST_RANGE;
      end
      CMD_WRITE: begin
        if (in_range) wr_ok = 1'b1;
        else          st    = ST_RANGE;
      end
      CMD_APPEND: begin
        if (full) st     = ST_FULL;
        else      app_ok = 1'b1;
      end
      CMD_INSERT: begin
        if (index > live_cnt) st     = ST_RANGE;
        else if (full)        st     = ST_FULL;
        else                  ins_ok = 1'b1;
      end
      CMD_DELETE: begin
        if (in_range) del_ok = 1'b1;
        else          st     = ST_RANGE;
      end
      CMD_RESIZE: begin
        if (index > CAP_IDX) st     = ST_FULL;
        else                 rsz_ok = 1'b1;
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  // Count after this request
  always_comb begin
    cnt_next = live_cnt;
    priority if (app_ok || ins_ok) begin
      cnt_next = live_cnt + IDX_W'(1);
    end else if (del_ok) begin
      cnt_next = live_cnt - IDX_W'(1);
    end else if (rsz_ok) begin
      cnt_next = index;
    end else begin
      cnt_next = live_cnt;
    end
  end

  assign status_next = st;

  // Broadcast the update only for an accepted request
  assign ctl.wr  = go & wr_ok;
  assign ctl.app = go & app_ok;
  assign ctl.ins = go & ins_ok;
  assign ctl.del = go & del_ok;
  assign ctl.rsz = go & rsz_ok;
  assign ctl.idx = index;
  assign ctl.cnt = live_cnt;
  assign ctl.val = write_value;

  // Advance the live count
  always_ff @(posedge clk) begin
    if (rst) begin
      live_cnt <= '0;
    end else if (go) begin
      live_cnt <= cnt_next;
    end
  end

  `IIDA_ASSERT_SAME(a_cnt_cap, 1'b1, live_cnt <= CAP_IDX, "live count above capacity")
  `IIDA_ASSERT_NEXT(a_app_inc, go && ctl.app, live_cnt == $past(live_cnt) + IDX_W'(1), "append did not grow count")
  `IIDA_ASSERT_SAME(a_full_hold, status_next == ST_FULL, cnt_next == live_cnt && !ctl.app && !ctl.ins, "full request changed state")

endmodule

### rtl/core/indexed_insert_delete_array.sv
// Top level of the indexed insert/delete array: control, cell chain, result register.
// Uses iida_pkg, iida_ctrl and iida_cell.
//
// Usage:
//   Requests arrive on in_valid/in_stall with command, index and write_value.
//   A request is taken at a clock edge with in_valid high and in_stall low.
//   Each request yields one result on out_valid/out_stall carrying
//   read_value, status and count.
//   The result is registered at the edge that takes the request.
//   Throughput is one request per cycle unless a held result stalls; every
//   element of the row of cells shifts in the same cycle, so insert and delete
//   cost no more than a read. The read word comes from an OR bus over all cells.
//   While a result waits and out_stall is high, in_stall is raised and the
//   result holds; a request is taken in the same cycle the held result
//   drains.
//   Reset (rst, synchronous) empties the array and drops any pending result.
//   Element words are not cleared; slots come to life only through append,
//   insert or the zero fill of a growing resize.
module indexed_insert_delete_array (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  command,
  input  logic [iida_pkg::IDX_W-1:0]  index,
  input  logic [iida_pkg::WORD_W-1:0] write_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [iida_pkg::WORD_W-1:0] read_value,
  output logic [1:0]                  status,
  output logic [iida_pkg::IDX_W-1:0]  count
);
  import iida_pkg::*;

  logic              go;
  cell_ctl_t         ctl;
  logic              rd_ok;
  logic [1:0]        status_next;
  logic [IDX_W-1:0]  cnt_next;
  logic [WORD_W-1:0] words [CAPACITY];
  logic [WORD_W-1:0] sel_words [CAPACITY];
  logic [WORD_W-1:0] rd_bus;

  assign in_stall = out_valid & out_stall;
  assign go       = in_valid & ~in_stall;

  iida_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .command     (command),
    .index       (index),
    .write_value (write_value),
    .ctl         (ctl),
    .rd_ok       (rd_ok),
    .status_next (status_next),
    .cnt_next    (cnt_next)
  );

  // Build the chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = words[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = words[g+1];
    end

    iida_cell u_cell (
      .clk        (clk),
      .pos        (POS_W'(g)),
      .ctl        (ctl),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[g]),
      .sel_word   (sel_words[g])
    );
  end

  // Merge the addressed word onto the read bus
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | sel_words[i];
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      read_value <= rd_ok ? rd_bus : '0;
      status     <= status_next;
      count      <= cnt_next;
    end
  end

endmodule

### verif/tb.sv
// Self-checking testbench for indexed_insert_delete_array: directed and random requests,
// with results compared against a behavioral shadow of the array in a scoreboard class.
// Depends on iida_pkg and the indexed_insert_delete_array RTL.
module tb;
  import iida_pkg::*;

  // Command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int NUM_RANDOM   = 1200;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PRINT_LIMIT  = 40;

  // Random traffic flavors
  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_CHURN  = 2;

  // Receiver stall patterns
  localparam int STALL_NONE     = 0;
  localparam int STALL_COIN     = 1;
  localparam int STALL_PERIODIC = 2;

  typedef struct {
    logic [WORD_W-1:0] rd;
    logic [1:0]        st;
    logic [IDX_W-1:0]  cnt;
  } array_result_t;

  // Shadow copy of the array and the queue of results it predicts
  class array_scoreboard;
    bit [WORD_W-1:0] shadow [CAPACITY];
    int unsigned     live;
    int unsigned     errors;
    array_result_t   awaited [$];

    task report(input string msg);
      if (errors < PRINT_LIMIT) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    // Apply one accepted request to the shadow and queue its result
    task note_request(input logic [2:0] c, input logic [IDX_W-1:0] i,
                      input logic [WORD_W-1:0] v);
      array_result_t r;
      int k;
      r.rd = '0;
      r.st = ST_OK;
      case (c)
        CMD_READ: begin
          if (i < live) r.rd = shadow[i];
          else r.st = ST_RANGE;
        end
        CMD_WRITE: begin
          if (i < live) shadow[i] = v;
          else r.st = ST_RANGE;
        end
        CMD_APPEND: begin
          if (live >= CAPACITY) begin
            r.st = ST_FULL;
          end else begin
            shadow[live] = v;
            live++;
          end
        end
        CMD_INSERT: begin
          // Range test comes before the full test
          if (i > live) begin
            r.st = ST_RANGE;
          end else if (live >= CAPACITY) begin
            r.st = ST_FULL;
          end else begin
            for (k = live; k > i; k--) shadow[k] = shadow[k-1];
            shadow[i] = v;
            live++;
          end
        end
        CMD_DELETE: begin
          if (i >= live) begin
            r.st = ST_RANGE;
          end else begin
            for (k = i; k + 1 < live; k++) shadow[k] = shadow[k+1];
            live--;
          end
        end
        CMD_RESIZE: begin
          if (i > CAPACITY) begin
            r.st = ST_FULL;
          end else begin
            // Zero-fill slots that come back to life
            for (k = live; k < i; k++) shadow[k] = '0;
            live = i;
          end
        end
        default: begin
        end
      endcase
      r.cnt = IDX_W'(live);
      awaited.push_back(r);
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(input logic [WORD_W-1:0] rd, input logic [1:0] st,
                      input logic [IDX_W-1:0] cnt);
      array_result_t w;
      if (awaited.size() == 0) begin
        report("result arrived with no request outstanding");
        return;
      end
      w = awaited.pop_front();
      if (rd !== w.rd) report($sformatf("read_value %h, predicted %h", rd, w.rd));
      if (st !== w.st) report($sformatf("status %0d, predicted %0d", st, w.st));
      if (cnt !== w.cnt) report($sformatf("count %0d, predicted %0d", cnt, w.cnt));
    endtask

    function int pending();
      return awaited.size();
    endfunction

    task finish_check();
      if (awaited.size() != 0)
        report($sformatf("%0d results never arrived", awaited.size()));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        command = '0;
  logic [IDX_W-1:0]  index = '0;
  logic [WORD_W-1:0] write_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] read_value;
  logic [1:0]        status;
  logic [IDX_W-1:0]  count;

  array_scoreboard book = new();
  int idle_cycles = 0;

  indexed_insert_delete_array DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .index       (index),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .status      (status),
    .count       (count)
  );

  always #4 clk = ~clk;

  // Present one request and hold it until taken
  task automatic send_request(input logic [2:0] c, input logic [IDX_W-1:0] i,
                              input logic [WORD_W-1:0] v);
    in_valid    <= 1'b1;
    command     <= c;
    index       <= i;
    write_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_request(c, i, v);
  endtask

  function automatic logic [2:0] pick_command(input int mode);
    int weight [7];
    logic [2:0] codes [7];
    int r;
    int acc;
    codes = '{CMD_APPEND, CMD_INSERT, CMD_WRITE, CMD_READ, CMD_DELETE, CMD_RESIZE,
              CMD_SPARE_LO};
    case (mode)
      MODE_GROW:   weight = '{35, 25, 10, 12, 8, 7, 3};
      MODE_SHRINK: weight = '{8, 8, 12, 14, 43, 12, 3};
      default:     weight = '{16, 16, 16, 18, 18, 13, 3};
    endcase
    r = $urandom_range(99, 0);
    acc = 0;
    for (int n = 0; n < 6; n++) begin
      acc += weight[n];
      if (r < acc) return codes[n];
    end
    return $urandom_range(1, 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
  endfunction

  // Mostly in-range positions, with boundaries and some noise up to 127
  function automatic logic [IDX_W-1:0] pick_index(input logic [2:0] c, input int live);
    int r;
    int lo;
    int hi;
    r = $urandom_range(99, 0);
    if (r < 8) return IDX_W'($urandom_range(127, 0));
    case (c)
      CMD_RESIZE: begin
        if (r < 25) return IDX_W'(CAPACITY);
        if (r < 35) return '0;
        if (r < 42) return IDX_W'(CAPACITY + 1);
        lo = (live > 4) ? live - 4 : 0;
        hi = (live + 4 > CAPACITY) ? CAPACITY : live + 4;
        return IDX_W'($urandom_range(hi, lo));
      end
      CMD_INSERT: begin
        if (r < 20) return IDX_W'(live);
        return IDX_W'($urandom_range(live, 0));
      end
      default: begin
        if (live == 0) return IDX_W'($urandom_range(2, 0));
        if (r < 20) return IDX_W'(live - 1);
        if (r < 25) return IDX_W'(live);
        return IDX_W'($urandom_range(live - 1, 0));
      end
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(99, 0);
    if (r < 5) return '1;
    if (r < 10) return '0;
    if (r < 15) return 64'd1 << $urandom_range(63, 0);
    return {$urandom, $urandom};
  endfunction

  // Walk the edge cases: empty array, shifting, resize, full array, unused codes
  task automatic run_directed();
    send_request(CMD_READ, 0, '0);
    send_request(CMD_DELETE, 0, '0);
    send_request(CMD_WRITE, 0, '1);
    send_request(CMD_INSERT, 1, 64'h1111_2222_3333_4444);
    send_request(CMD_INSERT, 0, '1);
    send_request(CMD_APPEND, 0, '0);
    send_request(CMD_INSERT, 1, 64'h0123_4567_89AB_CDEF);
    send_request(CMD_READ, 1, '0);
    send_request(CMD_DELETE, 0, '0);
    send_request(CMD_READ, 0, '0);
    send_request(CMD_RESIZE, 5, '0);
    send_request(CMD_WRITE, 3, 64'hA5A5_A5A5_5A5A_5A5A);
    send_request(CMD_RESIZE, 2, '0);
    send_request(CMD_RESIZE, 4, '0);
    send_request(CMD_READ, 3, '0);
    send_request(CMD_RESIZE, IDX_W'(CAPACITY + 1), '0);
    send_request(CMD_RESIZE, '1, '0);
    send_request(CMD_RESIZE, IDX_W'(CAPACITY), '0);
    send_request(CMD_APPEND, 0, 64'hDEAD_BEEF_0000_0001);
    send_request(CMD_INSERT, IDX_W'(CAPACITY + 1), '1);
    send_request(CMD_INSERT, IDX_W'(CAPACITY), '1);
    send_request(CMD_READ, IDX_W'(CAPACITY), '0);
    send_request(CMD_DELETE, IDX_W'(CAPACITY - 1), '0);
    send_request(CMD_SPARE_LO, 3, '1);
    send_request(CMD_SPARE_HI, '1, '1);
    send_request(CMD_RESIZE, 0, '0);
  endtask

  // Random requests in bursts, switching traffic flavor now and then
  task automatic run_random();
    int sent;
    int burst;
    int gap;
    int mode;
    logic [2:0] c;
    sent = 0;
    mode = MODE_GROW;
    while (sent < NUM_RANDOM) begin
      burst = $urandom_range(48, 1);
      for (int n = 0; n < burst && sent < NUM_RANDOM; n++) begin
        if (sent % 150 == 0) mode = $urandom_range(MODE_CHURN, MODE_GROW);
        c = pick_command(mode);
        send_request(c, pick_index(c, book.live), pick_word());
        sent++;
      end
      if ($urandom_range(3, 0) != 0) begin
        gap = $urandom_range(10, 1);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stall the result channel in stretches of varying pattern
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(3, 0);
      span = $urandom_range(150, 10);
      for (int phase = 0; phase < span; phase++) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_COIN:     out_stall <= ($urandom_range(1, 0) != 0);
          STALL_PERIODIC: out_stall <= ((phase % 5) < 3);
          default:        out_stall <= ($urandom_range(3, 0) != 0);
        endcase
      end
    end
  end

  // Check every result taken
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) book.check_result(read_value, status, count);
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    in_valid <= 1'b0;
    // Drain outstanding results, then allow stray ones to show up
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    book.finish_check();
    if (book.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
